FILE: sv/terrain_water_flow_step_defines.svh
// Assertion macros shared by the water flow step RTL.
// Depends on a clock named clock and a reset named reset in the including module.
`ifndef TERRAIN_WATER_FLOW_STEP_DEFINES_SVH
`define TERRAIN_WATER_FLOW_STEP_DEFINES_SVH

// Property must hold at every clock edge outside reset.
`define TWF_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("twf assertion failed");

// Condition must never be seen outside reset.
`define TWF_NEVER(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error("twf forbidden condition");

`endif

FILE: sv/twf_pkg.sv
// Shared types and constants of the terrain water flow step.
// No dependencies.
package twf_pkg;

   localparam int HEIGHT_W = 24;
   localparam int WATER_W  = 24;
   localparam int SRC_W    = 2;
   localparam int CELL_W   = WATER_W + SRC_W;
   localparam int ROW_W    = 6;
   localparam int COL_W    = 6;
   localparam int CSR_W    = 7;
   localparam int CSR_IDX_W = 1;

   localparam int DEF_MAX_ROWS = 64;
   localparam int DEF_MAX_COLS = 64;
   localparam logic [CSR_W-1:0] DEF_IN_USE = 7'd64;

   localparam logic [WATER_W-1:0] WATER_MAX = 24'hFF_FFFF;

   typedef enum logic [1:0] {
      KIND_LOAD   = 2'd0,
      KIND_SOURCE = 2'd1,
      KIND_TICK   = 2'd2,
      KIND_READ   = 2'd3
   } kind_type;

   localparam logic [CSR_IDX_W-1:0] CSR_ROWS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS = 1'b1;

   typedef struct packed {
      logic [HEIGHT_W-1:0] cen_h;
      logic [WATER_W-1:0]  cen_w;
      logic [HEIGHT_W-1:0] nb_h;
      logic [WATER_W-1:0]  nb_w;
   } flow_in_type;

   typedef struct packed {
      logic [WATER_W-1:0] cen_w;
      logic [WATER_W-1:0] nb_w;
   } flow_out_type;

endpackage

FILE: sv/terrain_water_flow_step.sv
// Top level of the terrain water flow step: sequencer, grid memories, output register.
// Depends on twf_pkg, twf_ram, twf_flow and terrain_water_flow_step_defines.svh.
//
//   channel | ports                                   | direction
//   req     | req_valid req_stall req_kind/row/col/value | in  (item: load, source, tick, read)
//   rsp     | rsp_valid rsp_stall rsp_water_depth/tick_done | out (item: read depth or tick done)
//   csr     | csr_we csr_index csr_wdata              | in  (rows_in_use, cols_in_use)
//
// Load writes the terrain RAM. Source write: one read-modify-write of the cell RAM. Read: one
// cell RAM read. Tick: a dry interior cell reads only its centre, a wet one also makes 4
// neighbour read/write pairs on the cell RAM; then every in-use cell is read and written for
// the source fill. Reset: synchronous; afterwards a clearing pass over all MAX_ROWS*MAX_COLS
// cells zeroes water and source counts, with req_stall high. Terrain is not cleared.
// One item at a time; a finished result sits in the output register while the next item enters.
`include "terrain_water_flow_step_defines.svh"

module terrain_water_flow_step #(
   parameter int MAX_ROWS = twf_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS = twf_pkg::DEF_MAX_COLS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_kind,
   input  logic [twf_pkg::ROW_W-1:0]           req_row,
   input  logic [twf_pkg::COL_W-1:0]           req_col,
   input  logic signed [twf_pkg::HEIGHT_W-1:0] req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [twf_pkg::WATER_W-1:0]         rsp_water_depth,
   output logic                                rsp_tick_done,
   input  logic                                csr_we,
   input  logic [twf_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [twf_pkg::CSR_W-1:0]           csr_wdata
);

   localparam int CELLS = MAX_ROWS * MAX_COLS;
   localparam int AW    = $clog2(CELLS);
   localparam int IRW   = $clog2(MAX_ROWS);
   localparam int ICW   = $clog2(MAX_COLS);
   localparam int NRW   = $clog2(MAX_ROWS + 1);
   localparam int NCW   = $clog2(MAX_COLS + 1);
   localparam int XRW   = (NRW > twf_pkg::CSR_W) ? NRW : twf_pkg::CSR_W;
   localparam int XCW   = (NCW > twf_pkg::CSR_W) ? NCW : twf_pkg::CSR_W;
   localparam logic [AW-1:0] COLS_A = AW'(MAX_COLS);
   localparam logic [AW-1:0] LAST_A = AW'(CELLS - 1);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_SRC_WR, S_RD_WAIT, S_SW_RD, S_SW_CEN,
      S_NB_RD, S_NB_EX, S_CEN_WR, S_FILL_RD, S_FILL_WR, S_RESP
   } state_type;

   state_type state_ff;
   logic [AW-1:0]  clr_ff;
   logic [AW-1:0]  addr_ff;
   logic [1:0]     src_ff;
   logic [IRW-1:0] i_ff;
   logic [ICW-1:0] j_ff;
   logic [1:0]     nb_ff;
   logic [twf_pkg::HEIGHT_W-1:0] cen_h_ff;
   logic [twf_pkg::WATER_W-1:0]  cen_w_ff;
   logic [1:0]                   cen_src_ff;
   logic [twf_pkg::WATER_W-1:0]  res_w_ff;
   logic                         res_tick_ff;
   logic [twf_pkg::CSR_W-1:0]    rows_ff;
   logic [twf_pkg::CSR_W-1:0]    cols_ff;
   logic                         rsp_valid_ff;
   logic [twf_pkg::WATER_W-1:0]  rsp_w_ff;
   logic                         rsp_tick_ff;

   logic [NRW-1:0] nr;
   logic [NCW-1:0] nc;
   logic           interior_ok;
   logic           fill_ok;
   logic           row_more2;
   logic           col_more2;
   logic           row_more1;
   logic           col_more1;
   logic           accept;
   logic           req_inside;
   logic [AW-1:0]  req_addr;
   logic [AW-1:0]  idx_addr;
   logic [AW-1:0]  nb_addr;
   logic [1:0]     req_src;
   logic           rsp_free;

   logic                        cell_we;
   logic [AW-1:0]               cell_waddr;
   logic [twf_pkg::CELL_W-1:0]  cell_wdata;
   logic                        mem_re;
   logic [AW-1:0]               mem_raddr;
   logic [twf_pkg::CELL_W-1:0]  cell_rdata;
   logic                        ter_we;
   logic [twf_pkg::HEIGHT_W-1:0] ter_rdata;
   logic [24:0]                 fill_sum;

   twf_pkg::flow_in_type  fl_in;
   twf_pkg::flow_out_type fl_out;

   // Clamp the size registers to the grid and derive the sweep bounds.
   always_comb begin
      nr = (XRW'(rows_ff) > XRW'(MAX_ROWS)) ? NRW'(MAX_ROWS) : NRW'(rows_ff);
      nc = (XCW'(cols_ff) > XCW'(MAX_COLS)) ? NCW'(MAX_COLS) : NCW'(cols_ff);
      interior_ok = (nr >= NRW'(3)) && (nc >= NCW'(3));
      fill_ok     = (nr != '0) && (nc != '0);
      row_more2 = ({1'b0, NRW'(i_ff)} + (NRW+1)'(2)) < {1'b0, nr};
      col_more2 = ({1'b0, NCW'(j_ff)} + (NCW+1)'(2)) < {1'b0, nc};
      row_more1 = ({1'b0, NRW'(i_ff)} + (NRW+1)'(1)) < {1'b0, nr};
      col_more1 = ({1'b0, NCW'(j_ff)} + (NCW+1)'(1)) < {1'b0, nc};
   end

   assign accept     = req_valid && !req_stall;
   assign req_stall  = (state_ff != S_IDLE);
   assign req_inside = (11'(req_row) < 11'(MAX_ROWS)) && (11'(req_col) < 11'(MAX_COLS));
   assign req_addr   = AW'(req_row) * COLS_A + AW'(req_col);
   assign idx_addr   = AW'(i_ff) * COLS_A + AW'(j_ff);
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   // Saturate a negative count to 0 and a large one to 3.
   always_comb begin
      if (req_value[23]) begin
         req_src = 2'd0;
      end else if (|req_value[22:2]) begin
         req_src = 2'd3;
      end else begin
         req_src = req_value[1:0];
      end
   end

   // Neighbour order: up, left, down, right.
   always_comb begin
      case (nb_ff)
         2'd0:    nb_addr = idx_addr - COLS_A;
         2'd1:    nb_addr = idx_addr - AW'(1);
         2'd2:    nb_addr = idx_addr + COLS_A;
         default: nb_addr = idx_addr + AW'(1);
      endcase
   end

   // Read port address.
   always_comb begin
      mem_re    = 1'b0;
      mem_raddr = idx_addr;
      unique case (state_ff)
         S_IDLE: begin
            mem_re    = accept;
            mem_raddr = req_addr;
         end
         S_SW_RD, S_FILL_RD: mem_re = 1'b1;
         S_NB_RD: begin
            mem_re    = 1'b1;
            mem_raddr = nb_addr;
         end
         default: mem_re = 1'b0;
      endcase
   end

   assign fl_in.cen_h = cen_h_ff;
   assign fl_in.cen_w = cen_w_ff;
   assign fl_in.nb_h  = ter_rdata;
   assign fl_in.nb_w  = cell_rdata[twf_pkg::WATER_W-1:0];

   assign fill_sum = {1'b0, cell_rdata[twf_pkg::WATER_W-1:0]}
                   + {15'd0, cell_rdata[twf_pkg::CELL_W-1:twf_pkg::WATER_W], 8'd0};

   // Cell RAM write port: {source count, water}.
   always_comb begin
      cell_we    = 1'b0;
      cell_waddr = idx_addr;
      cell_wdata = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cell_we    = 1'b1;
            cell_waddr = clr_ff;
         end
         S_SRC_WR: begin
            cell_we    = 1'b1;
            cell_waddr = addr_ff;
            cell_wdata = {src_ff, cell_rdata[twf_pkg::WATER_W-1:0]};
         end
         S_NB_EX: begin
            cell_we    = 1'b1;
            cell_waddr = nb_addr;
            cell_wdata = {cell_rdata[twf_pkg::CELL_W-1:twf_pkg::WATER_W], fl_out.nb_w};
         end
         S_CEN_WR: begin
            cell_we    = 1'b1;
            cell_wdata = {cen_src_ff, cen_w_ff};
         end
         S_FILL_WR: begin
            cell_we    = 1'b1;
            cell_wdata = {cell_rdata[twf_pkg::CELL_W-1:twf_pkg::WATER_W],
                          fill_sum[24] ? twf_pkg::WATER_MAX : fill_sum[23:0]};
         end
         default: cell_we = 1'b0;
      endcase
   end

   assign ter_we = (state_ff == S_IDLE) && accept && req_inside
                && (twf_pkg::kind_type'(req_kind) == twf_pkg::KIND_LOAD);

   twf_ram #(.WIDTH(twf_pkg::CELL_W), .DEPTH(CELLS)) u_cell_ram (
      .clock (clock),
      .we    (cell_we),
      .waddr (cell_waddr),
      .wdata (cell_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (cell_rdata)
   );

   twf_ram #(.WIDTH(twf_pkg::HEIGHT_W), .DEPTH(CELLS)) u_terrain_ram (
      .clock (clock),
      .we    (ter_we),
      .waddr (req_addr),
      .wdata (req_value),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (ter_rdata)
   );

   twf_flow u_flow (
      .fin  (fl_in),
      .fout (fl_out)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rows_ff      <= twf_pkg::DEF_IN_USE;
         cols_ff      <= twf_pkg::DEF_IN_USE;
         rsp_valid_ff <= 1'b0;
         i_ff         <= '0;
         j_ff         <= '0;
         nb_ff        <= '0;
      end else begin
         if (csr_we) begin
            if (csr_index == twf_pkg::CSR_ROWS) begin
               rows_ff <= csr_wdata;
            end else begin
               cols_ff <= csr_wdata;
            end
         end
         // drop the shown result once taken; S_RESP reloads it in the same cycle
         if (rsp_valid_ff && !rsp_stall && (state_ff != S_RESP)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + AW'(1);
               if (clr_ff == LAST_A) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (accept) begin
                  addr_ff <= req_addr;
                  src_ff  <= req_src;
                  unique case (twf_pkg::kind_type'(req_kind))
                     twf_pkg::KIND_LOAD: state_ff <= S_IDLE;
                     twf_pkg::KIND_SOURCE: begin
                        if (req_inside) begin
                           state_ff <= S_SRC_WR;
                        end
                     end
                     twf_pkg::KIND_TICK: begin
                        res_w_ff    <= '0;
                        res_tick_ff <= 1'b1;
                        if (interior_ok) begin
                           i_ff     <= IRW'(1);
                           j_ff     <= ICW'(1);
                           state_ff <= S_SW_RD;
                        end else if (fill_ok) begin
                           i_ff     <= '0;
                           j_ff     <= '0;
                           state_ff <= S_FILL_RD;
                        end else begin
                           state_ff <= S_RESP;
                        end
                     end
                     twf_pkg::KIND_READ: begin
                        res_w_ff    <= '0;
                        res_tick_ff <= 1'b0;
                        state_ff    <= req_inside ? S_RD_WAIT : S_RESP;
                     end
                     default: state_ff <= S_IDLE;
                  endcase
               end
            end
            S_SRC_WR: state_ff <= S_IDLE;
            S_RD_WAIT: begin
               res_w_ff <= cell_rdata[twf_pkg::WATER_W-1:0];
               state_ff <= S_RESP;
            end
            S_SW_RD: state_ff <= S_SW_CEN;
            S_SW_CEN: begin
               // hold the center in registers for its four exchanges
               cen_h_ff   <= ter_rdata;
               cen_w_ff   <= cell_rdata[twf_pkg::WATER_W-1:0];
               cen_src_ff <= cell_rdata[twf_pkg::CELL_W-1:twf_pkg::WATER_W];
               nb_ff      <= '0;
               if (cell_rdata[twf_pkg::WATER_W-1:0] != '0) begin
                  state_ff <= S_NB_RD;
               end else if (col_more2) begin
                  j_ff     <= j_ff + ICW'(1);
                  state_ff <= S_SW_RD;
               end else if (row_more2) begin
                  i_ff     <= i_ff + IRW'(1);
                  j_ff     <= ICW'(1);
                  state_ff <= S_SW_RD;
               end else begin
                  i_ff     <= '0;
                  j_ff     <= '0;
                  state_ff <= S_FILL_RD;
               end
            end
            S_NB_RD: state_ff <= S_NB_EX;
            S_NB_EX: begin
               cen_w_ff <= fl_out.cen_w;
               nb_ff    <= nb_ff + 2'd1;
               state_ff <= (nb_ff == 2'd3) ? S_CEN_WR : S_NB_RD;
            end
            S_CEN_WR: begin
               if (col_more2) begin
                  j_ff     <= j_ff + ICW'(1);
                  state_ff <= S_SW_RD;
               end else if (row_more2) begin
                  i_ff     <= i_ff + IRW'(1);
                  j_ff     <= ICW'(1);
                  state_ff <= S_SW_RD;
               end else begin
                  i_ff     <= '0;
                  j_ff     <= '0;
                  state_ff <= S_FILL_RD;
               end
            end
            S_FILL_RD: state_ff <= S_FILL_WR;
            S_FILL_WR: begin
               if (col_more1) begin
                  j_ff     <= j_ff + ICW'(1);
                  state_ff <= S_FILL_RD;
               end else if (row_more1) begin
                  i_ff     <= i_ff + IRW'(1);
                  j_ff     <= '0;
                  state_ff <= S_FILL_RD;
               end else begin
                  state_ff <= S_RESP;
               end
            end
            S_RESP: begin
               // advance into the output register when it is free
               if (rsp_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_w_ff     <= res_w_ff;
                  rsp_tick_ff  <= res_tick_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_water_depth = rsp_w_ff;
   assign rsp_tick_done   = rsp_tick_ff;

   `TWF_ASSERT(a_rsp_from_resp, $rose(rsp_valid) |-> $past(state_ff == S_RESP))
   `TWF_ASSERT(a_sweep_interior, (state_ff == S_NB_EX) |-> (i_ff != '0 && j_ff != '0))
   `TWF_NEVER(a_rw_overlap, cell_we && mem_re && (cell_waddr == mem_raddr))
   `TWF_ASSERT(a_tick_result_zero, (rsp_valid && rsp_tick_done) |-> (rsp_water_depth == '0))

endmodule

FILE: sv/twf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module twf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: sv/twf_flow.sv
// One exchange between a cell and a neighbour: level compare, move and saturate.
// Depends on twf_pkg.
module twf_flow (
   input  twf_pkg::flow_in_type  fin,
   output twf_pkg::flow_out_type fout
);

   logic signed [25:0] lvl_a;
   logic signed [25:0] lvl_b;
   logic [26:0]        diff;
   logic               move;
   logic [23:0]        amt;
   logic [24:0]        nb_sum;

   always_comb begin
      lvl_a  = $signed({{2{fin.cen_h[23]}}, fin.cen_h}) + $signed({2'b00, fin.cen_w});
      lvl_b  = $signed({{2{fin.nb_h[23]}}, fin.nb_h}) + $signed({2'b00, fin.nb_w});
      diff   = {lvl_a[25], lvl_a} - {lvl_b[25], lvl_b};
      move   = !diff[26] && (diff != 27'd0);
      // move the smaller of own water and the level gap
      amt    = ({3'b000, fin.cen_w} < diff) ? fin.cen_w : diff[23:0];
      nb_sum = {1'b0, fin.nb_w} + {1'b0, amt};
      if (move) begin
         fout.cen_w = fin.cen_w - amt;
         fout.nb_w  = nb_sum[24] ? twf_pkg::WATER_MAX : nb_sum[23:0];
      end else begin
         fout.cen_w = fin.cen_w;
         fout.nb_w  = fin.nb_w;
      end
   end

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for terrain_water_flow_step: a scoreboard predicts the
// water sweep and compares every response. Depends on twf_pkg and the block's RTL.
`timescale 1ns / 100ps

module testbench;

   localparam int  ROW_W       = twf_pkg::ROW_W;
   localparam int  COL_W       = twf_pkg::COL_W;
   localparam int  HEIGHT_W    = twf_pkg::HEIGHT_W;
   localparam int  WATER_W     = twf_pkg::WATER_W;
   localparam int  SRC_W       = twf_pkg::SRC_W;
   localparam int  CSR_W       = twf_pkg::CSR_W;
   localparam int  CSR_IDX_W   = twf_pkg::CSR_IDX_W;
   localparam int  GRID_COLS   = 64;
   localparam int  CELL_COUNT  = 64 * 64;
   localparam int  CYCLE_LIMIT = 3000000;
   localparam int  IDLE_CYCLES = 8;
   // Every terrain cell in this corner is loaded; once water exists, sweeps stay inside it.
   localparam int  LOADED      = 6;

   // Grid model: heights, depths and source counts, swept the way the block does.
   class flow_scoreboard;
      typedef struct {
         logic [WATER_W-1:0] depth;
         logic               done;
      } response_type;

      logic signed [HEIGHT_W-1:0] height [CELL_COUNT];
      logic [WATER_W-1:0]         water [CELL_COUNT];
      logic [SRC_W-1:0]           sources [CELL_COUNT];
      logic [CSR_W-1:0]           rows_reg;
      logic [CSR_W-1:0]           cols_reg;
      response_type               expected_q[$];
      int                         errors;
      int                         mismatches;

      function new();
         foreach (height[k]) begin
            height[k]  = '0;
            water[k]   = '0;
            sources[k] = '0;
         end
         rows_reg   = twf_pkg::DEF_IN_USE;
         cols_reg   = twf_pkg::DEF_IN_USE;
         errors     = 0;
         mismatches = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] v);
         if (idx == twf_pkg::CSR_ROWS) rows_reg = v;
         else cols_reg = v;
      endfunction

      function logic [WATER_W-1:0] sat_add(logic [WATER_W-1:0] a, longint b);
         longint s;
         s = longint'(a) + b;
         return (s > longint'(twf_pkg::WATER_MAX)) ? twf_pkg::WATER_MAX : s[WATER_W-1:0];
      endfunction

      function void sweep();
         int     nr, nc, k, k2;
         longint lvl_a, lvl_b, diff, moved;
         nr = (rows_reg > 64) ? 64 : rows_reg;
         nc = (cols_reg > 64) ? 64 : cols_reg;
         if (nr >= 3 && nc >= 3) begin
            for (int i = 1; i + 1 < nr; i++) begin
               for (int j = 1; j + 1 < nc; j++) begin
                  k = i * GRID_COLS + j;
                  if (water[k] == 0) continue;
                  // up, left, down, right
                  for (int n = 0; n < 4; n++) begin
                     case (n)
                        0: k2 = (i - 1) * GRID_COLS + j;
                        1: k2 = k - 1;
                        2: k2 = (i + 1) * GRID_COLS + j;
                        default: k2 = k + 1;
                     endcase
                     lvl_a = longint'(height[k]) + longint'(water[k]);
                     lvl_b = longint'(height[k2]) + longint'(water[k2]);
                     if (lvl_a > lvl_b) begin
                        diff  = lvl_a - lvl_b;
                        moved = (longint'(water[k]) < diff) ? longint'(water[k]) : diff;
                        water[k]  = water[k] - moved[WATER_W-1:0];
                        water[k2] = sat_add(water[k2], moved);
                     end
                  end
               end
            end
         end
         for (int i = 0; i < nr; i++)
            for (int j = 0; j < nc; j++) begin
               k = i * GRID_COLS + j;
               water[k] = sat_add(water[k], longint'(sources[k]) * 256);
            end
      endfunction

      function void note_item(twf_pkg::kind_type kind, logic [ROW_W-1:0] r,
                              logic [COL_W-1:0] c, logic signed [HEIGHT_W-1:0] v);
         int           k;
         response_type rsp;
         k = r * GRID_COLS + c;
         case (kind)
            twf_pkg::KIND_LOAD:   height[k] = v;
            twf_pkg::KIND_SOURCE: sources[k] = (v < 0) ? 2'd0 : ((v > 3) ? 2'd3 : v[1:0]);
            twf_pkg::KIND_TICK: begin
               sweep();
               rsp.depth = '0;
               rsp.done  = 1'b1;
               expected_q.push_back(rsp);
            end
            default: begin
               rsp.depth = water[k];
               rsp.done  = 1'b0;
               expected_q.push_back(rsp);
            end
         endcase
      endfunction

      function void check_result(logic [WATER_W-1:0] depth, logic done);
         response_type want;
         if (expected_q.size() == 0) begin
            errors++;
            if (mismatches++ < 10)
               $display("unexpected response: depth %0d tick_done %0b", depth, done);
            return;
         end
         want = expected_q.pop_front();
         if (depth !== want.depth || done !== want.done) begin
            errors++;
            if (mismatches++ < 10)
               $display("response mismatch: expected depth %0d tick_done %0b, got %0d %0b",
                        want.depth, want.done, depth, done);
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic [1:0]                  req_kind = '0;
   logic [ROW_W-1:0]            req_row = '0;
   logic [COL_W-1:0]            req_col = '0;
   logic signed [HEIGHT_W-1:0]  req_value = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [WATER_W-1:0]          rsp_water_depth;
   logic                        rsp_tick_done;
   logic                        csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]        csr_index = '0;
   logic [CSR_W-1:0]            csr_wdata = '0;

   flow_scoreboard grid_sb = new();
   int cycle_count = 0;
   int burst_left  = 0;
   int stall_mode  = 0;
   int stall_left  = 0;

   terrain_water_flow_step dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_kind(req_kind),
      .req_row(req_row), .req_col(req_col), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_water_depth(rsp_water_depth), .rsp_tick_done(rsp_tick_done),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // Watchdog: drop the run if it hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("terrain_water_flow_step verification failed");
         $finish;
      end
   end

   // Receiver: stall in stretches of free running, random and mostly-stalled modes.
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_left = $urandom_range(5, 60);
      end else begin
         stall_left--;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= 1'($urandom_range(0, 1));
         default: rsp_stall <= ($urandom_range(0, 3) != 0);
      endcase
   end

   // Check every accepted response against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         grid_sb.check_result(rsp_water_depth, rsp_tick_done);
   end

   // Present one item, hold it until accepted, then maybe open a gap.
   task automatic send_item(twf_pkg::kind_type kind, logic [ROW_W-1:0] r,
                            logic [COL_W-1:0] c, logic signed [HEIGHT_W-1:0] v,
                            bit no_gaps = 0);
      @(negedge clock);
      req_valid <= 1'b1;
      req_kind  <= kind;
      req_row   <= r;
      req_col   <= c;
      req_value <= v;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      grid_sb.note_item(kind, r, c, v);
      if (no_gaps || burst_left > 0) begin
         if (burst_left > 0) burst_left--;
      end else begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(0, 6)) @(negedge clock);
         burst_left = $urandom_range(0, 12);
      end
   endtask

   // Drain: hold valid low until every response is back and loads have settled.
   task automatic drain_block();
      @(negedge clock);
      req_valid <= 1'b0;
      while (grid_sb.pending() != 0) @(posedge clock);
      repeat (IDLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we    <= 1'b0;
      grid_sb.set_reg(idx, data);
   endtask

   task automatic random_item(int nr, int nc);
      int               pick, lim_r, lim_c;
      logic [ROW_W-1:0] r;
      logic [COL_W-1:0] c;
      logic signed [HEIGHT_W-1:0] v;
      lim_r = (nr > 64) ? 64 : ((nr < 1) ? 1 : nr);
      lim_c = (nc > 64) ? 64 : ((nc < 1) ? 1 : nc);
      // Mostly address the in-use grid; sometimes anywhere.
      r = ROW_W'(($urandom_range(0, 9) < 7) ? $urandom_range(0, lim_r - 1)
                                              : $urandom_range(0, 63));
      c = COL_W'(($urandom_range(0, 9) < 7) ? $urandom_range(0, lim_c - 1)
                                              : $urandom_range(0, 63));
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
         v = HEIGHT_W'(($urandom_range(0, 9) < 8) ? $urandom_range(0, 2047) - 1024
                                                   : $urandom);
         send_item(twf_pkg::KIND_LOAD, r, c, v);
      end else if (pick < 45) begin
         v = HEIGHT_W'(($urandom_range(0, 9) < 7) ? $urandom_range(0, 3) : $urandom);
         send_item(twf_pkg::KIND_SOURCE, r, c, v);
      end else if (pick < ((lim_r * lim_c > 400) ? 50 : 62)) begin
         send_item(twf_pkg::KIND_TICK, ROW_W'($urandom), COL_W'($urandom),
                   HEIGHT_W'($urandom));
      end else begin
         send_item(twf_pkg::KIND_READ, r, c, HEIGHT_W'($urandom));
      end
   endtask

   initial begin
      int rows_cfg [9] = '{6, 3, 4, 6, 3, 5, 2, 5, 50};
      int cols_cfg [9] = '{6, 3, 6, 3, 6, 4, 50, 0, 2};

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Oversized grid registers while the whole grid is still dry: a full clamped sweep.
      write_reg(twf_pkg::CSR_ROWS, 7'd127);
      write_reg(twf_pkg::CSR_COLS, 7'd127);
      send_item(twf_pkg::KIND_READ, 6'd63, 6'd63, 24'sd0);
      send_item(twf_pkg::KIND_TICK, 6'd63, 6'd63, -24'sd1);
      send_item(twf_pkg::KIND_READ, 6'd10, 6'd10, 24'sd0);
      drain_block();
      write_reg(twf_pkg::CSR_ROWS, CSR_W'(LOADED));
      write_reg(twf_pkg::CSR_COLS, CSR_W'(LOADED));

      // Give every terrain cell that a sweep can reach a height.
      for (int r = 0; r < LOADED; r++)
         for (int c = 0; c < LOADED; c++)
            send_item(twf_pkg::KIND_LOAD, ROW_W'(r), COL_W'(c),
                      HEIGHT_W'($urandom_range(0, 1023) - 256), 1);

      // Directed: field extremes, clamped source counts, a source outside the in-use grid.
      send_item(twf_pkg::KIND_LOAD, 6'd2, 6'd2, -24'sd8388608);
      send_item(twf_pkg::KIND_LOAD, 6'd2, 6'd3, 24'sd8388607);
      send_item(twf_pkg::KIND_SOURCE, 6'd2, 6'd3, 24'sd3);
      send_item(twf_pkg::KIND_SOURCE, 6'd3, 6'd3, -24'sd5);
      send_item(twf_pkg::KIND_SOURCE, 6'd3, 6'd2, 24'sd100);
      send_item(twf_pkg::KIND_SOURCE, 6'd0, 6'd0, 24'sd8388607);
      send_item(twf_pkg::KIND_SOURCE, 6'd40, 6'd30, 24'sd2);
      send_item(twf_pkg::KIND_READ, 6'd0, 6'd0, 24'sd0);
      send_item(twf_pkg::KIND_TICK, 6'd0, 6'd0, 24'sd0);
      send_item(twf_pkg::KIND_READ, 6'd2, 6'd2, 24'sd0);
      send_item(twf_pkg::KIND_READ, 6'd2, 6'd3, 24'sd0);
      send_item(twf_pkg::KIND_READ, 6'd40, 6'd30, 24'sd0);
      send_item(twf_pkg::KIND_TICK, 6'd0, 6'd0, 24'sd0);
      send_item(twf_pkg::KIND_READ, 6'd3, 6'd2, 24'sd0);

      // Random phases, each at a new grid size, extremes among them.
      foreach (rows_cfg[p]) begin
         drain_block();
         write_reg(twf_pkg::CSR_ROWS, CSR_W'(rows_cfg[p]));
         write_reg(twf_pkg::CSR_COLS, CSR_W'(cols_cfg[p]));
         repeat (5) random_item(rows_cfg[p], cols_cfg[p]);
         send_item(twf_pkg::KIND_TICK, 6'd0, 6'd0, 24'sd0);
      end

      drain_block();
      repeat (20) @(posedge clock);
      if (grid_sb.pending() != 0) grid_sb.errors++;
      if (grid_sb.errors == 0)
         $display("terrain_water_flow_step verification clean");
      else
         $display("terrain_water_flow_step verification failed");
      $finish;
   end

endmodule
